>>> src/ustv_pkg.sv
// shared types and constants for the utf8 text source validator
package ustv_pkg;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_OK           = 3'd0;
    localparam status_t STATUS_TOO_LARGE    = 3'd1;
    localparam status_t STATUS_BAD_MARK     = 3'd2;
    localparam status_t STATUS_BINARY       = 3'd3;
    localparam status_t STATUS_INVALID_UTF8 = 3'd4;

    localparam int LIMIT_BITS   = 24;
    localparam int CONTENT_BITS = 25;
    localparam int CP_BITS      = 21;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 24'hFF_FFFF;

    localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10_FFFF;
    localparam logic [CP_BITS-1:0] SURR_LO    = 21'h00_D800;
    localparam logic [CP_BITS-1:0] SURR_HI    = 21'h00_DFFF;
    localparam logic [CP_BITS-1:0] MIN_TWO    = 21'h00_0080;
    localparam logic [CP_BITS-1:0] MIN_THREE  = 21'h00_0800;
    localparam logic [CP_BITS-1:0] MIN_FOUR   = 21'h01_0000;

    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
    localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC2;
    localparam logic [7:0] BYTE_LEAD2_HI  = 8'hDF;
    localparam logic [7:0] BYTE_LEAD3_LO  = 8'hE0;
    localparam logic [7:0] BYTE_LEAD3_HI  = 8'hEF;
    localparam logic [7:0] BYTE_LEAD4_LO  = 8'hF0;
    localparam logic [7:0] BYTE_LEAD4_HI  = 8'hF4;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] BOM8_0         = 8'hEF;
    localparam logic [7:0] BOM8_1         = 8'hBB;
    localparam logic [7:0] BOM8_2         = 8'hBF;
    localparam logic [7:0] BOM_FE         = 8'hFE;
    localparam logic [7:0] BOM_FF         = 8'hFF;

    localparam logic [1:0] CLASS_TWO   = 2'd0;
    localparam logic [1:0] CLASS_THREE = 2'd1;
    localparam logic [1:0] CLASS_FOUR  = 2'd2;

endpackage

>>> src/utf8_text_source_validator.sv
// top level of the utf8 text source validator
// Takes a text source one byte word per cycle on the s_ channel and returns one verdict
// word (status and content byte count) on the m_ channel for each word marked last. Each
// word is captured in an input register and then handled by single-pass logic that
// updates the counters and the utf8 decoder and, on a last word, writes the result
// register, which drives the m_ channel. The block takes one word every cycle; it stalls
// only while a finished verdict waits in the result register and the next word in the
// input register is itself a last word. max_source_bytes is written through cfg_data
// whenever cfg_valid is high and holds 0xFFFFFF after reset. COUNT_BITS sets the width
// of the saturating byte and control counters.
module utf8_text_source_validator #(
    parameter int COUNT_BITS = 25
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_has_byte,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_status,
    output logic [ustv_pkg::CONTENT_BITS-1:0]    m_content_bytes,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ustv_pkg::LIMIT_BITS-1:0]      cfg_data
);

    localparam int CB = ustv_pkg::CONTENT_BITS;
    localparam int W  = (COUNT_BITS > CB) ? COUNT_BITS : CB;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [W-1:0] OUT_MAX = W'({CB{1'b1}});

    // configuration
    logic [ustv_pkg::LIMIT_BITS-1:0] limit_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // source state
    logic [COUNT_BITS-1:0] byte_total_reg, byte_total_next, byte_total_new;
    logic [COUNT_BITS-1:0] ctrl_total_reg, ctrl_total_next, ctrl_total_new;
    logic [7:0]            head_reg [4];
    logic [7:0]            head_next [4];
    logic [7:0]            head_new [4];
    logic                  zero_reg, zero_next, zero_new;
    logic [1:0]            pend_reg, pend_next, pend_new;
    logic [ustv_pkg::CP_BITS-1:0] part_reg, part_next, part_new;
    logic [1:0]            cls_reg, cls_next, cls_new;
    logic                  bad_reg, bad_next, bad_new;

    // result register
    logic                  m_valid_reg;
    ustv_pkg::status_t     status_reg, status_next;
    logic [CB-1:0]         content_reg, content_next;

    logic                  proc;
    logic                  is_ctrl;
    logic [ustv_pkg::CP_BITS-1:0] cp_next;
    logic [ustv_pkg::CP_BITS-1:0] cp_low;
    logic                  utf8_mark;
    logic                  other_mark;
    logic [COUNT_BITS-1:0] content;
    logic [W-1:0]          content_ext;
    logic [COUNT_BITS+3:0] ctrl_x10;
    logic [W-1:0]          n_ext;
    logic [W-1:0]          limit_ext;

    assign proc      = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_content_bytes = content_reg;

    assign is_ctrl = (in_data_reg < ustv_pkg::BYTE_SPACE || in_data_reg == ustv_pkg::BYTE_DEL)
                     && in_data_reg != ustv_pkg::BYTE_TAB
                     && in_data_reg != ustv_pkg::BYTE_LF
                     && in_data_reg != ustv_pkg::BYTE_CR;

    // counters and head bytes
    always_comb begin
        byte_total_new = byte_total_reg;
        ctrl_total_new = ctrl_total_reg;
        zero_new       = zero_reg;
        for (int i = 0; i < 4; i++) begin
            head_new[i] = head_reg[i];
        end
        if (in_has_reg) begin
            if (byte_total_reg < COUNT_BITS'(4)) begin
                head_new[byte_total_reg[1:0]] = in_data_reg;
            end
            if (byte_total_reg != CNT_MAX) begin
                byte_total_new = byte_total_reg + COUNT_BITS'(1);
            end
            if (in_data_reg == ustv_pkg::BYTE_ZERO) begin
                zero_new = 1'b1;
            end
            if (is_ctrl && ctrl_total_reg != CNT_MAX) begin
                ctrl_total_new = ctrl_total_reg + COUNT_BITS'(1);
            end
        end
    end

    // utf8 decoder
    assign cp_next = {part_reg[ustv_pkg::CP_BITS-7:0], in_data_reg[5:0]};

    always_comb begin
        case (cls_reg)
            ustv_pkg::CLASS_TWO:   cp_low = ustv_pkg::MIN_TWO;
            ustv_pkg::CLASS_THREE: cp_low = ustv_pkg::MIN_THREE;
            default:               cp_low = ustv_pkg::MIN_FOUR;
        endcase
    end

    always_comb begin
        pend_new = pend_reg;
        part_new = part_reg;
        cls_new  = cls_reg;
        bad_new  = bad_reg;
        if (in_has_reg && !bad_reg) begin
            if (pend_reg == 2'd0) begin
                if (in_data_reg <= ustv_pkg::BYTE_ASCII_MAX) begin
                    bad_new = 1'b0;
                end else if (in_data_reg >= ustv_pkg::BYTE_LEAD2_LO
                             && in_data_reg <= ustv_pkg::BYTE_LEAD2_HI) begin
                    pend_new = 2'd1;
                    part_new = {16'd0, in_data_reg[4:0]};
                    cls_new  = ustv_pkg::CLASS_TWO;
                end else if (in_data_reg >= ustv_pkg::BYTE_LEAD3_LO
                             && in_data_reg <= ustv_pkg::BYTE_LEAD3_HI) begin
                    pend_new = 2'd2;
                    part_new = {17'd0, in_data_reg[3:0]};
                    cls_new  = ustv_pkg::CLASS_THREE;
                end else if (in_data_reg >= ustv_pkg::BYTE_LEAD4_LO
                             && in_data_reg <= ustv_pkg::BYTE_LEAD4_HI) begin
                    pend_new = 2'd3;
                    part_new = {18'd0, in_data_reg[2:0]};
                    cls_new  = ustv_pkg::CLASS_FOUR;
                end else begin
                    bad_new = 1'b1;
                end
            end else if (in_data_reg[7:6] != 2'b10) begin
                bad_new = 1'b1;
            end else begin
                part_new = cp_next;
                pend_new = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    if (cp_next < cp_low || cp_next > ustv_pkg::CP_MAX
                        || (cp_next >= ustv_pkg::SURR_LO && cp_next <= ustv_pkg::SURR_HI)) begin
                        bad_new = 1'b1;
                    end
                end
            end
        end
    end

    // verdict
    assign utf8_mark = byte_total_new >= COUNT_BITS'(3)
                       && head_new[0] == ustv_pkg::BOM8_0
                       && head_new[1] == ustv_pkg::BOM8_1
                       && head_new[2] == ustv_pkg::BOM8_2;

    assign other_mark = (byte_total_new >= COUNT_BITS'(4)
                         && head_new[0] == ustv_pkg::BYTE_ZERO
                         && head_new[1] == ustv_pkg::BYTE_ZERO
                         && head_new[2] == ustv_pkg::BOM_FE
                         && head_new[3] == ustv_pkg::BOM_FF)
                     || (byte_total_new >= COUNT_BITS'(2)
                         && head_new[0] == ustv_pkg::BOM_FE
                         && head_new[1] == ustv_pkg::BOM_FF)
                     || (byte_total_new >= COUNT_BITS'(2)
                         && head_new[0] == ustv_pkg::BOM_FF
                         && head_new[1] == ustv_pkg::BOM_FE);

    assign content = (utf8_mark && byte_total_new != CNT_MAX)
                     ? byte_total_new - COUNT_BITS'(3) : byte_total_new;

    assign content_ext = W'(content);
    assign n_ext       = W'(byte_total_new);
    assign limit_ext   = W'(limit_reg);
    assign ctrl_x10    = {1'b0, ctrl_total_new, 3'b000} + {3'b000, ctrl_total_new, 1'b0};

    always_comb begin
        if (n_ext > limit_ext) begin
            status_next = ustv_pkg::STATUS_TOO_LARGE;
        end else if (other_mark) begin
            status_next = ustv_pkg::STATUS_BAD_MARK;
        end else if (content != '0
                     && (zero_new || ctrl_x10 > (COUNT_BITS+4)'(content))) begin
            status_next = ustv_pkg::STATUS_BINARY;
        end else if (bad_new || pend_new != 2'd0) begin
            status_next = ustv_pkg::STATUS_INVALID_UTF8;
        end else begin
            status_next = ustv_pkg::STATUS_OK;
        end
        content_next = (content_ext > OUT_MAX) ? OUT_MAX[CB-1:0] : content_ext[CB-1:0];
    end

    // state clears after each verdict
    always_comb begin
        if (in_last_reg) begin
            byte_total_next = '0;
            ctrl_total_next = '0;
            zero_next       = 1'b0;
            pend_next       = 2'd0;
            part_next       = '0;
            cls_next        = ustv_pkg::CLASS_TWO;
            bad_next        = 1'b0;
            for (int i = 0; i < 4; i++) begin
                head_next[i] = 8'd0;
            end
        end else begin
            byte_total_next = byte_total_new;
            ctrl_total_next = ctrl_total_new;
            zero_next       = zero_new;
            pend_next       = pend_new;
            part_next       = part_new;
            cls_next        = cls_new;
            bad_next        = bad_new;
            for (int i = 0; i < 4; i++) begin
                head_next[i] = head_new[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ustv_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_has_reg  <= s_has_byte;
            in_last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg <= '0;
            ctrl_total_reg <= '0;
            zero_reg       <= 1'b0;
            pend_reg       <= 2'd0;
            part_reg       <= '0;
            cls_reg        <= ustv_pkg::CLASS_TWO;
            bad_reg        <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                head_reg[i] <= 8'd0;
            end
        end else if (proc) begin
            byte_total_reg <= byte_total_next;
            ctrl_total_reg <= ctrl_total_next;
            zero_reg       <= zero_next;
            pend_reg       <= pend_next;
            part_reg       <= part_next;
            cls_reg        <= cls_next;
            bad_reg        <= bad_next;
            for (int i = 0; i < 4; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_last_reg) begin
            status_reg  <= status_next;
            content_reg <= content_next;
        end
    end

endmodule

>>> src/ustv_checker.sv
// port checker for the utf8 text source validator and its bind
module ustv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [2:0]                        m_status,
    input logic [ustv_pkg::CONTENT_BITS-1:0] m_content_bytes
);

    // no verdict right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("verdict word valid after reset");

    // stalled verdict holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_content_bytes))
        else $error("stalled verdict word changed");

    // status code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ustv_pkg::STATUS_INVALID_UTF8)
        else $error("status code out of range");

    // binary verdict needs content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ustv_pkg::STATUS_BINARY |-> m_content_bytes != '0)
        else $error("binary verdict on empty content");

endmodule

bind utf8_text_source_validator ustv_checker u_ustv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_content_bytes (m_content_bytes)
);
